FILE: rtl/tts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

   // Field widths
   localparam int TEMP_W   = 10;
   localparam int TIMER_W  = 16;
   localparam int CAP_W    = 7;
   localparam int LIMITS_W = 35;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 35;
   localparam int ANT_W    = 2;
   // Level index as seen by the cap selector (wide enough for sixteen levels)
   localparam int LVL_EXT_W = 4;

   // Default number of throughput caps
   localparam int NUM_LEVELS_DEF = 5;

   // Fixed antenna hysteresis and full-rate cap
   localparam int ANT_OFF_TEMP = 105;
   localparam int WARN_HYST = 25;
   localparam logic signed [TEMP_W-1:0] WARN_ON  = TEMP_W'(ANT_OFF_TEMP);
   localparam logic signed [TEMP_W-1:0] WARN_OFF = TEMP_W'(ANT_OFF_TEMP - WARN_HYST);
   localparam logic [CAP_W-1:0] FULL_RATE = CAP_W'(100);
   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

   // Register reset values
   localparam logic signed [TEMP_W-1:0] HIGH_THRESHOLD_RST = TEMP_W'(95);
   localparam logic signed [TEMP_W-1:0] LOW_THRESHOLD_RST  = TEMP_W'(85);
   localparam logic [TIMER_W-1:0]  STEP_INTERVAL_RST = TIMER_W'(10);
   localparam logic [TIMER_W-1:0]  MAX_COOL_TIME_RST = TIMER_W'(600);
   localparam logic [LIMITS_W-1:0] STEP_LIMITS_RST   = LIMITS_W'(64'd27054912100);

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE         = 3'd0,
      CSR_HIGH_THRESHOLD = 3'd1,
      CSR_LOW_THRESHOLD  = 3'd2,
      CSR_STEP_INTERVAL  = 3'd3,
      CSR_MAX_COOL_TIME  = 3'd4,
      CSR_STEP_LIMITS    = 3'd5,
      CSR_WARN_ENABLE    = 3'd6
   } csr_index_type;

   // Antenna action codes
   typedef enum logic [ANT_W-1:0] {
      ANT_NONE    = 2'd0,
      ANT_OFF     = 2'd1,
      ANT_RESTORE = 2'd2
   } antenna_type;

   // Saturating timer increment
   function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] t);
      return (t == TIMER_MAX) ? t : t + TIMER_W'(1);
   endfunction

   // Cap of level k: 7-bit field at bits 7k, zero beyond the register
   function automatic logic [CAP_W-1:0] cap_of(input logic [LIMITS_W-1:0] limits,
                                                input logic [2:0] k);
      logic [CAP_W-1:0] cap;
      cap = '0;
      unique case (k)
         3'd0: cap = limits[6:0];
         3'd1: cap = limits[13:7];
         3'd2: cap = limits[20:14];
         3'd3: cap = limits[27:21];
         3'd4: cap = limits[34:28];
         default: cap = '0;
      endcase
      return cap;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/thermal_throttle_stepper.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_temperature
// rsp       out        rsp_valid/rsp_ready    rsp_limit_valid, rsp_limit_percent,
//                                             rsp_antenna_action, rsp_cooling_active
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// Each request gives one response, registered in the input then the result stage.
// A request is accepted every cycle while rsp_ready is high; the state update
// reads the input register and the state registers and writes the state registers.
// Active-high synchronous reset clears state and valid bits and resets the CSRs.
// A stalled response holds the result register; the input register still fills,
// then req_ready drops until the response is taken. csr_ready is always high.

module thermal_throttle_stepper #(
   parameter int NUM_LEVELS = tts_pkg::NUM_LEVELS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [tts_pkg::TEMP_W-1:0]   req_temperature,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_limit_valid,
   output logic [tts_pkg::CAP_W-1:0]                rsp_limit_percent,
   output logic [tts_pkg::ANT_W-1:0]                rsp_antenna_action,
   output logic                                     rsp_cooling_active,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tts_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int LEVEL_W = $clog2(NUM_LEVELS + 1);

   // Configuration registers
   logic                                   enable_ff;
   logic signed [tts_pkg::TEMP_W-1:0]      high_thr_ff;
   logic signed [tts_pkg::TEMP_W-1:0]      low_thr_ff;
   logic [tts_pkg::TIMER_W-1:0]            step_interval_ff;
   logic [tts_pkg::TIMER_W-1:0]            max_cool_ff;
   logic [tts_pkg::LIMITS_W-1:0]           step_limits_ff;
   logic                                   warn_enable_ff;

   // Throttle state
   logic                                   cooling_ff, cooling_in;
   logic [tts_pkg::TIMER_W-1:0]            step_timer_ff, step_timer_in;
   logic [tts_pkg::TIMER_W-1:0]            cool_timer_ff, cool_timer_in;
   logic [LEVEL_W-1:0]                     level_ff, level_in;
   logic                                   warn_ff, warn_in;

   // Input stage
   logic                                   in_valid_ff;
   logic signed [tts_pkg::TEMP_W-1:0]      in_temp_ff;

   // Result stage
   logic                                   out_valid_ff;
   logic                                   out_limit_valid_ff, out_limit_valid_in;
   logic [tts_pkg::CAP_W-1:0]              out_pct_ff, out_pct_in;
   tts_pkg::antenna_type                   out_ant_ff, out_ant_in;
   logic                                   out_cool_ff;

   logic                                   advance;
   logic [tts_pkg::LVL_EXT_W-1:0]          lvl_ext;
   logic                                   finish;
   logic                                   step;
   logic [tts_pkg::TIMER_W-1:0]            step_base;
   logic [tts_pkg::TIMER_W-1:0]            cool_base;

   // Handshake
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff        <= 1'b0;
         high_thr_ff      <= tts_pkg::HIGH_THRESHOLD_RST;
         low_thr_ff       <= tts_pkg::LOW_THRESHOLD_RST;
         step_interval_ff <= tts_pkg::STEP_INTERVAL_RST;
         max_cool_ff      <= tts_pkg::MAX_COOL_TIME_RST;
         step_limits_ff   <= tts_pkg::STEP_LIMITS_RST;
         warn_enable_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tts_pkg::CSR_ENABLE:         enable_ff        <= csr_data[0];
            tts_pkg::CSR_HIGH_THRESHOLD: high_thr_ff      <= csr_data[tts_pkg::TEMP_W-1:0];
            tts_pkg::CSR_LOW_THRESHOLD:  low_thr_ff       <= csr_data[tts_pkg::TEMP_W-1:0];
            tts_pkg::CSR_STEP_INTERVAL:  step_interval_ff <= csr_data[tts_pkg::TIMER_W-1:0];
            tts_pkg::CSR_MAX_COOL_TIME:  max_cool_ff      <= csr_data[tts_pkg::TIMER_W-1:0];
            tts_pkg::CSR_STEP_LIMITS:    step_limits_ff   <= csr_data[tts_pkg::LIMITS_W-1:0];
            tts_pkg::CSR_WARN_ENABLE:    warn_enable_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_temp_ff <= req_temperature;
      end
   end

   assign lvl_ext = tts_pkg::LVL_EXT_W'(level_ff);

   // Compute next state and result
   always_comb begin
      cooling_in         = cooling_ff;
      step_timer_in      = step_timer_ff;
      cool_timer_in      = cool_timer_ff;
      level_in           = level_ff;
      warn_in            = warn_ff;
      out_limit_valid_in = 1'b0;
      out_pct_in         = '0;
      out_ant_in         = tts_pkg::ANT_NONE;
      finish             = 1'b0;
      step               = 1'b0;
      step_base          = step_timer_ff;
      cool_base          = cool_timer_ff;

      if (enable_ff) begin
         // Antenna hysteresis
         if (warn_enable_ff) begin
            if (in_temp_ff >= tts_pkg::WARN_ON && !warn_ff) begin
               warn_in    = 1'b1;
               out_ant_in = tts_pkg::ANT_OFF;
            end else if (in_temp_ff <= tts_pkg::WARN_OFF && warn_ff) begin
               warn_in    = 1'b0;
               out_ant_in = tts_pkg::ANT_RESTORE;
            end
         end

         // Cooling control
         priority if (!cooling_ff) begin
            if (in_temp_ff >= high_thr_ff) begin
               cooling_in         = 1'b1;
               out_limit_valid_in = 1'b1;
               out_pct_in         = tts_pkg::cap_of(step_limits_ff, lvl_ext[2:0]);
               step_timer_in      = tts_pkg::sat_inc(step_timer_ff);
               cool_timer_in      = tts_pkg::sat_inc(cool_timer_ff);
               if (lvl_ext < tts_pkg::LVL_EXT_W'(7)) begin
                  level_in = level_ff + LEVEL_W'(1);
               end
            end
         end else if (in_temp_ff > low_thr_ff || in_temp_ff >= high_thr_ff) begin
            if (in_temp_ff >= high_thr_ff) begin
               cool_base = '0;
               step      = 1'b1;
            end else if (step_timer_ff == step_interval_ff) begin
               step = 1'b1;
            end
            if (step) begin
               if (lvl_ext < tts_pkg::LVL_EXT_W'(NUM_LEVELS)) begin
                  out_limit_valid_in = 1'b1;
                  out_pct_in         = tts_pkg::cap_of(step_limits_ff, lvl_ext[2:0]);
                  level_in           = level_ff + LEVEL_W'(1);
               end
               step_base = '0;
            end
            step_timer_in = tts_pkg::sat_inc(step_base);
            cool_timer_in = tts_pkg::sat_inc(cool_base);
            if (cool_timer_in == max_cool_ff) begin
               finish = 1'b1;
            end
         end else begin
            finish = 1'b1;
         end

         // End cooling at full rate
         if (finish) begin
            cooling_in         = 1'b0;
            step_timer_in      = '0;
            cool_timer_in      = '0;
            level_in           = '0;
            out_limit_valid_in = 1'b1;
            out_pct_in         = tts_pkg::FULL_RATE;
         end
      end
   end

   // Advance state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         cooling_ff    <= 1'b0;
         step_timer_ff <= '0;
         cool_timer_ff <= '0;
         level_ff      <= '0;
         warn_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            cooling_ff    <= cooling_in;
            step_timer_ff <= step_timer_in;
            cool_timer_ff <= cool_timer_in;
            level_ff      <= level_in;
            warn_ff       <= warn_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_limit_valid_ff <= out_limit_valid_in;
         out_pct_ff         <= out_pct_in;
         out_ant_ff         <= out_ant_in;
         out_cool_ff        <= cooling_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_limit_valid    = out_limit_valid_ff;
   assign rsp_limit_percent  = out_pct_ff;
   assign rsp_antenna_action = out_ant_ff;
   assign rsp_cooling_active = out_cool_ff;

endmodule

`default_nettype wire

FILE: rtl/tts_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tts_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic                            rsp_limit_valid,
   input wire logic [tts_pkg::CAP_W-1:0]       rsp_limit_percent,
   input wire logic [tts_pkg::ANT_W-1:0]       rsp_antenna_action
);

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_limit_percent)
                                 && $stable(rsp_antenna_action))
      else $error("stalled response changed");

   // No cap issued means a zero percent field
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_limit_valid |-> rsp_limit_percent == '0)
      else $error("percent set without a cap");

   // Only the three antenna codes appear
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_antenna_action == tts_pkg::ANT_NONE
                 || rsp_antenna_action == tts_pkg::ANT_OFF
                 || rsp_antenna_action == tts_pkg::ANT_RESTORE)
      else $error("bad antenna action");

endmodule

bind thermal_throttle_stepper tts_checker u_tts_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_limit_valid    (rsp_limit_valid),
   .rsp_limit_percent  (rsp_limit_percent),
   .rsp_antenna_action (rsp_antenna_action)
);

`default_nettype wire
